/* rtl/core/luhn_pkg.sv */
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared types and constants for the Luhn card number classifier.
// ----------------------------------------------------------------------------
package luhn_pkg;

    localparam int CARD_W     = 63;
    localparam int BCD_DIGITS = 19;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEP_BITS  = 3;
    localparam int CONV_STEPS = CARD_W / STEP_BITS;
    localparam int IDX_W      = 5;
    localparam int CAT_W      = 2;

    // prefix and length constants
    localparam logic [6:0] PFX15_A   = 7'd34;
    localparam logic [6:0] PFX15_B   = 7'd37;
    localparam logic [6:0] PFX16_LO  = 7'd51;
    localparam logic [6:0] PFX16_HI  = 7'd55;
    localparam logic [3:0] LEAD_FOUR = 4'd4;
    localparam logic [IDX_W-1:0] LEN_13 = 5'd13;
    localparam logic [IDX_W-1:0] LEN_15 = 5'd15;
    localparam logic [IDX_W-1:0] LEN_16 = 5'd16;

    typedef enum logic [CAT_W-1:0] {
        CAT_INVALID,
        CAT_FIFTEEN,
        CAT_SIXTEEN,
        CAT_LEAD4
    } luhn_cat_t;

    typedef struct packed {
        logic             load;
        logic             conv;
        logic             scan;
        logic [IDX_W-1:0] idx;
        logic             publish;
    } luhn_cmd_t;

endpackage

/* rtl/core/luhn_ctrl.sv */
// ----------------------------------------------------------------------------
// luhn_ctrl
// Sequencer: binary-to-BCD conversion, digit scan, result hand-off.
// ----------------------------------------------------------------------------
module luhn_ctrl #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output luhn_pkg::luhn_cmd_t cmd
);
    import luhn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_FIN
    } state_t;

    localparam logic [IDX_W-1:0] CONV_LAST = IDX_W'(CONV_STEPS - 1);
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_DIGITS - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] step_reg;
    logic             out_valid_reg;
    logic             take;

    assign take      = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.idx     = step_reg;
        cmd.load    = (state_reg == ST_IDLE) && in_valid;
        cmd.conv    = (state_reg == ST_CONV);
        cmd.scan    = (state_reg == ST_SCAN);
        // output register free, or emptied at this edge
        cmd.publish = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    if (step_reg == CONV_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (step_reg == SCAN_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_FIN:
                begin
                    if (cmd.publish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/luhn_dp.sv */
// ----------------------------------------------------------------------------
// luhn_dp
// Datapath: 3-bit-per-cycle double dabble, one-digit-per-cycle Luhn scan,
// classification and output register.
// ----------------------------------------------------------------------------
module luhn_dp #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                          clk,
    input  luhn_pkg::luhn_cmd_t           cmd,
    input  logic [luhn_pkg::CARD_W-1:0]   card_number,
    output logic [luhn_pkg::CAT_W-1:0]    category,
    output logic                          checksum_ok,
    output logic [luhn_pkg::IDX_W-1:0]    digit_count
);
    import luhn_pkg::*;

    localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(MAX_DIGITS);

    logic [CARD_W-1:0] bin_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [3:0]        total_reg;
    logic [IDX_W-1:0]  count_reg;
    logic [3:0]        lead_reg;
    logic [6:0]        lead2_reg;
    logic [3:0]        prev_reg;
    luhn_cat_t         category_reg;
    logic              checksum_ok_reg;
    logic [IDX_W-1:0]  digit_count_reg;

    logic [CARD_W-1:0] conv_bin;
    logic [BCD_W-1:0]  conv_bcd;

    logic [3:0]        scan_digit;
    logic [3:0]        scan_dbl;
    logic [3:0]        scan_add;
    logic [4:0]        scan_sum;
    logic [3:0]        scan_total;
    logic [6:0]        scan_lead2;

    logic              cls_ok;
    logic              cls_ovf;
    luhn_cat_t         cls_cat;

    // shift-add-3 over STEP_BITS input bits
    always_comb
    begin
        conv_bcd = bcd_reg;
        conv_bin = bin_reg;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int i = 0; i < BCD_DIGITS; i++)
            begin
                if (conv_bcd[4*i +: 4] >= 4'd5)
                begin
                    conv_bcd[4*i +: 4] = conv_bcd[4*i +: 4] + 4'd3;
                end
            end
            conv_bcd = {conv_bcd[BCD_W-2:0], conv_bin[CARD_W-1]};
            conv_bin = {conv_bin[CARD_W-2:0], 1'b0};
        end
    end

    // one digit per cycle, lowest first; total kept mod 10
    always_comb
    begin
        scan_digit = bcd_reg[3:0];
        scan_dbl   = (scan_digit < 4'd5) ? {scan_digit[2:0], 1'b0}
                                         : 4'({scan_digit, 1'b0} - 5'd9);
        scan_add   = cmd.idx[0] ? scan_dbl : scan_digit;
        scan_sum   = {1'b0, total_reg} + {1'b0, scan_add};
        scan_total = (scan_sum >= 5'd10) ? 4'(scan_sum - 5'd10) : scan_sum[3:0];
        if (cmd.idx == '0)
        begin
            scan_lead2 = {3'b000, scan_digit};
        end
        else
        begin
            scan_lead2 = {scan_digit, 3'b000} + {2'b00, scan_digit, 1'b0}
                       + {3'b000, prev_reg};
        end
    end

    // digits left above the scanned window mean too long a number
    always_comb
    begin
        cls_ok  = (total_reg == 4'd0);
        cls_ovf = |bcd_reg;
        cls_cat = CAT_INVALID;
        if (cls_ok && !cls_ovf)
        begin
            if ((count_reg == LEN_15) && ((lead2_reg == PFX15_A) || (lead2_reg == PFX15_B)))
            begin
                cls_cat = CAT_FIFTEEN;
            end
            else if ((count_reg == LEN_16) && (lead2_reg >= PFX16_LO)
                     && (lead2_reg <= PFX16_HI))
            begin
                cls_cat = CAT_SIXTEEN;
            end
            else if ((count_reg >= LEN_13) && (count_reg <= LEN_16)
                     && (lead_reg == LEAD_FOUR))
            begin
                cls_cat = CAT_LEAD4;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg   <= card_number;
            bcd_reg   <= '0;
            total_reg <= '0;
            count_reg <= '0;
            lead_reg  <= '0;
            lead2_reg <= '0;
            prev_reg  <= '0;
        end
        else if (cmd.conv)
        begin
            bin_reg <= conv_bin;
            bcd_reg <= conv_bcd;
        end
        else if (cmd.scan)
        begin
            bcd_reg   <= {4'b0000, bcd_reg[BCD_W-1:4]};
            total_reg <= scan_total;
            prev_reg  <= scan_digit;
            if (scan_digit != 4'd0)
            begin
                count_reg <= cmd.idx + 1'b1;
                lead_reg  <= scan_digit;
                lead2_reg <= scan_lead2;
            end
        end

        if (cmd.publish)
        begin
            category_reg    <= cls_cat;
            checksum_ok_reg <= cls_ok;
            // too long a number reports the full window as its length
            digit_count_reg <= cls_ovf ? COUNT_MAX : count_reg;
        end
    end

    assign category    = category_reg;
    assign checksum_ok = checksum_ok_reg;
    assign digit_count = digit_count_reg;

endmodule

/* rtl/core/luhn_card_number_classifier.sv */
// ----------------------------------------------------------------------------
// luhn_card_number_classifier
// Each item is converted from binary to BCD (3 bits a cycle), then scanned
// one digit a cycle and published; the next item is accepted only after that.
// A result waiting in the output register does not hold up conversion and
// scan of the next item, but that item's result waits until it is taken.
// Reset: rst_n asynchronous, active low; clears sequencer and out_valid.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [luhn_pkg::CARD_W-1:0] card_number,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [luhn_pkg::CAT_W-1:0]  category,
    output logic                        checksum_ok,
    output logic [luhn_pkg::IDX_W-1:0]  digit_count
);
    import luhn_pkg::*;

    luhn_cmd_t cmd;

    luhn_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    luhn_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .card_number (card_number),
        .category    (category),
        .checksum_ok (checksum_ok),
        .digit_count (digit_count)
    );

endmodule

/* rtl/core/luhn_chk.sv */
// ----------------------------------------------------------------------------
// luhn_chk
// Port-level checker for the Luhn card number classifier, bound to the top.
// ----------------------------------------------------------------------------
module luhn_chk #(
    parameter int MAX_DIGITS = 19
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [luhn_pkg::CAT_W-1:0]  category,
    input logic                        checksum_ok,
    input logic [luhn_pkg::IDX_W-1:0]  digit_count
);
    import luhn_pkg::*;

    // one item at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous item in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(category)
                                      && $stable(checksum_ok) && $stable(digit_count)))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_count <= MAX_DIGITS))
        else $error("digit count above limit");

    a_cat_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (category != CAT_INVALID)) |-> checksum_ok)
        else $error("category given with failed checksum");

    a_cat15_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (category == CAT_FIFTEEN)) |-> (digit_count == LEN_15))
        else $error("fifteen-digit category with wrong length");

endmodule

bind luhn_card_number_classifier luhn_chk #(
    .MAX_DIGITS (MAX_DIGITS)
) u_luhn_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .category    (category),
    .checksum_ok (checksum_ok),
    .digit_count (digit_count)
);
